@@ sv/hvp_pkg.sv @@
// hvp_pkg: constants and the arctangent table for the home vector polar block
// no dependencies; imported by home_vector_polar, hvp_checker and the testbench

package hvp_pkg;

    // rotation unit
    localparam int CORDIC_STEPS   = 31;
    localparam int PRESCALE_SHIFT = 28;
    localparam int ACC_BITS       = 32;   // angle accumulator scale, 2^31 = pi
    localparam int ACC_W          = 34;   // accumulator width with headroom
    localparam int ATAN_W         = 30;

    localparam logic signed [ACC_W-1:0] ACC_QUARTER = 34'sd1073741824;

    // atan(2^-i) with 2^31 = pi, rounded to nearest
    localparam logic [ATAN_W-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1
    };

    // result item
    localparam int DIST_W = 16;
    localparam int HEAD_W = 16;
    localparam int OUT_W  = DIST_W + HEAD_W;

endpackage

@@ sv/home_vector_polar.sv @@
// home_vector_polar: distance and heading from a robot position back to home
// pipelined integer square root beside a pipelined vectoring rotator; uses hvp_pkg
//
//   channel  | ports            | tdata, lowest bits first
//   ---------+------------------+------------------------------------------
//   input    | s_axis_t*        | x_position, y_position (COORD_BITS each)
//   result   | m_axis_t*        | distance_home (16), heading_home (16)
//
// one position enters every cycle while s_axis_tready is high
// the depth is set by the 31 rotation steps and the COORD_BITS root digits, one per stage
// reset clears all valid bits and the two-entry output buffer
// a result that waits on m_axis_tready fills the second output entry, and the
// pipeline and s_axis_tready then hold until that entry drains

module home_vector_polar
    import hvp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // x_position, y_position
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // distance_home, heading_home
    output logic [OUT_W-1:0]                    m_axis_tdata
);

    localparam int C    = COORD_BITS;
    localparam int A    = ANGLE_BITS;
    localparam int W    = COORD_BITS + 32;
    localparam int SQ_W = 2 * COORD_BITS;
    localparam int NS   = (CORDIC_STEPS > COORD_BITS) ? CORDIC_STEPS : COORD_BITS;
    localparam int SH   = ACC_BITS - ANGLE_BITS;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'd1 << SH) >>> 1;
    localparam logic [A-1:0] HEAD_PI      = {1'b1, {(A-1){1'b0}}};
    localparam logic [A-1:0] HEAD_UP      = {2'b01, {(A-2){1'b0}}};
    localparam logic [A-1:0] HEAD_DOWN    = {2'b11, {(A-2){1'b0}}};

    logic en;
    logic push;
    logic [OUT_W-1:0] push_data;

    // ---------------- entry stage: fold, squares, axis cases ----------------
    logic [C-1:0] x_in, y_in;
    logic signed [W-1:0] u_pre, v_pre, u_sc, v_sc;
    logic [C-1:0] ax, ay;

    logic                     p0_vld_reg;
    logic signed [W-1:0]      p0_u_reg, p0_v_reg, p0_u_next, p0_v_next;
    logic signed [ACC_W-1:0]  p0_acc_reg, p0_acc_next;
    logic [SQ_W-1:0]          p0_sqx_reg, p0_sqy_reg, p0_sqx_next, p0_sqy_next;
    logic                     p0_spec_reg, p0_spec_next;
    logic [A-1:0]             p0_shead_reg, p0_shead_next;

    assign x_in = s_axis_tdata[C-1:0];
    assign y_in = s_axis_tdata[2*C-1:C];

    always_comb begin
        // vector toward home is the negated position
        u_pre = -{{(W-C){x_in[C-1]}}, x_in};
        v_pre = -{{(W-C){y_in[C-1]}}, y_in};
        u_sc  = u_pre <<< PRESCALE_SHIFT;
        v_sc  = v_pre <<< PRESCALE_SHIFT;
        p0_u_next   = u_sc;
        p0_v_next   = v_sc;
        p0_acc_next = '0;
        if (u_sc[W-1]) begin
            if (!v_sc[W-1]) begin
                p0_u_next   = v_sc;
                p0_v_next   = -u_sc;
                p0_acc_next = ACC_QUARTER;
            end else begin
                p0_u_next   = -v_sc;
                p0_v_next   = u_sc;
                p0_acc_next = -ACC_QUARTER;
            end
        end

        ax = x_in[C-1] ? -x_in : x_in;
        ay = y_in[C-1] ? -y_in : y_in;
        p0_sqx_next = SQ_W'(ax) * SQ_W'(ax);
        p0_sqy_next = SQ_W'(ay) * SQ_W'(ay);

        // exact headings on the axes and at home
        p0_spec_next  = 1'b1;
        p0_shead_next = '0;
        if (x_in == '0 && y_in == '0) begin
            p0_shead_next = '0;
        end else if (y_in == '0) begin
            p0_shead_next = x_in[C-1] ? '0 : HEAD_PI;
        end else if (x_in == '0) begin
            p0_shead_next = y_in[C-1] ? HEAD_UP : HEAD_DOWN;
        end else begin
            p0_spec_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_u_reg     <= p0_u_next;
            p0_v_reg     <= p0_v_next;
            p0_acc_reg   <= p0_acc_next;
            p0_sqx_reg   <= p0_sqx_next;
            p0_sqy_reg   <= p0_sqy_next;
            p0_spec_reg  <= p0_spec_next;
            p0_shead_reg <= p0_shead_next;
        end
    end

    // ---------------- step pipeline ----------------
    // index 0 holds the sum of squares stage, index j+1 the output of step j
    logic                     vld_reg   [0:NS];
    logic signed [W-1:0]      u_reg     [0:NS];
    logic signed [W-1:0]      v_reg     [0:NS];
    logic signed [ACC_W-1:0]  acc_reg   [0:NS];
    logic [SQ_W-1:0]          n_reg     [0:NS];
    logic [SQ_W-1:0]          r_reg     [0:NS];
    logic                     spec_reg  [0:NS];
    logic [A-1:0]             shead_reg [0:NS];

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[0]     <= p0_u_reg;
            v_reg[0]     <= p0_v_reg;
            acc_reg[0]   <= p0_acc_reg;
            n_reg[0]     <= p0_sqx_reg + p0_sqy_reg;
            r_reg[0]     <= '0;
            spec_reg[0]  <= p0_spec_reg;
            shead_reg[0] <= p0_shead_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            p0_vld_reg <= s_axis_tvalid;
            vld_reg[0] <= p0_vld_reg;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic signed [W-1:0]     u_next, v_next;
        logic signed [ACC_W-1:0] acc_next;
        logic [SQ_W-1:0]         n_next, r_next;

        if (j < CORDIC_STEPS) begin : g_rot
            localparam logic signed [ACC_W-1:0] ANG =
                {{(ACC_W-ATAN_W){1'b0}}, ATAN_TAB[j]};
            always_comb begin
                // rotate toward the x axis by the sign of v
                if (!v_reg[j][W-1] && (v_reg[j] != '0)) begin
                    u_next   = u_reg[j] + (v_reg[j] >>> j);
                    v_next   = v_reg[j] - (u_reg[j] >>> j);
                    acc_next = acc_reg[j] + ANG;
                end else begin
                    u_next   = u_reg[j] - (v_reg[j] >>> j);
                    v_next   = v_reg[j] + (u_reg[j] >>> j);
                    acc_next = acc_reg[j] - ANG;
                end
            end
        end else begin : g_rot_hold
            assign u_next   = u_reg[j];
            assign v_next   = v_reg[j];
            assign acc_next = acc_reg[j];
        end

        if (j < C) begin : g_root
            localparam logic [SQ_W-1:0] RBIT = SQ_W'(1) << (SQ_W - 2 - 2*j);
            logic [SQ_W:0] trial;
            assign trial = {1'b0, r_reg[j]} + {1'b0, RBIT};
            always_comb begin
                if ({1'b0, n_reg[j]} >= trial) begin
                    n_next = n_reg[j] - trial[SQ_W-1:0];
                    r_next = (r_reg[j] >> 1) + RBIT;
                end else begin
                    n_next = n_reg[j];
                    r_next = r_reg[j] >> 1;
                end
            end
        end else begin : g_root_hold
            assign n_next = n_reg[j];
            assign r_next = r_reg[j];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                u_reg[j+1]     <= u_next;
                v_reg[j+1]     <= v_next;
                acc_reg[j+1]   <= acc_next;
                n_reg[j+1]     <= n_next;
                r_reg[j+1]     <= r_next;
                spec_reg[j+1]  <= spec_reg[j];
                shead_reg[j+1] <= shead_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end
    end

    // ---------------- rounding and wrap ----------------
    logic signed [ACC_W-1:0] rnd_sum, rnd_shift;
    logic [A-1:0]            head_a;
    logic [ACC_W-1:0]        head_ext;

    always_comb begin
        rnd_sum   = acc_reg[NS] + HALF;
        rnd_shift = rnd_sum >>> SH;
        head_a    = spec_reg[NS] ? shead_reg[NS] : rnd_shift[A-1:0];
        head_ext  = {{(ACC_W-A){head_a[A-1]}}, head_a};
        push_data = {head_ext[HEAD_W-1:0], r_reg[NS][DIST_W-1:0]};
    end

    assign push = en && vld_reg[NS];

    // ---------------- two-entry output buffer ----------------
    logic             out_vld_reg, out_vld_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic             skid_vld_reg, skid_vld_next;
    logic [OUT_W-1:0] skid_data_reg, skid_data_next;
    logic             out_free;

    always_comb begin
        out_free       = !out_vld_reg || m_axis_tready;
        out_vld_next   = out_vld_reg;
        out_data_next  = out_data_reg;
        skid_vld_next  = skid_vld_reg;
        skid_data_next = skid_data_reg;
        if (skid_vld_reg) begin
            if (out_free) begin
                out_vld_next  = 1'b1;
                out_data_next = skid_data_reg;
                skid_vld_next = 1'b0;
            end
        end else if (push) begin
            if (out_free) begin
                out_vld_next  = 1'b1;
                out_data_next = push_data;
            end else begin
                skid_vld_next  = 1'b1;
                skid_data_next = push_data;
            end
        end else if (m_axis_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ sv/hvp_checker.sv @@
// hvp_checker: port-level checks on the home vector polar block
// uses hvp_pkg; bound to home_vector_polar at the end of this file

module hvp_checker
    import hvp_pkg::*;
#(
    parameter int IN_W = 32
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // items taken in and not yet handed out
    logic [7:0] pend_reg, pend_next;
    logic       s_xfer, m_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign m_xfer = m_axis_tvalid && m_axis_tready;

    always_comb begin
        pend_next = pend_reg;
        if (s_xfer && !m_xfer) begin
            pend_next = pend_reg + 8'd1;
        end else if (!s_xfer && m_xfer) begin
            pend_next = pend_reg - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // no result without an item behind it
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (pend_reg != 8'd0))
        else $error("result transfer offered with no item outstanding");

    // input side only stalls while a result is waiting
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // offered position held while the input is stalled
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("offered position changed while stalled");

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // reset empties the result side
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind home_vector_polar hvp_checker #(
    .IN_W(((2*COORD_BITS+7)/8)*8)
) u_hvp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/testbench.sv @@
// testbench for home_vector_polar: streams signed positions in, checks distance and heading
// against an in-bench root and rotation predictor; depends on hvp_pkg and home_vector_polar
`timescale 1ns / 100ps

module testbench;
    import hvp_pkg::*;

    localparam int XY_W        = 16;
    localparam int PIPE_DEPTH  = 34;
    localparam int TAIL_CYCLES = 3 * PIPE_DEPTH;
    localparam int RANDOM_ITEMS = 850;
    localparam int IDLE_PCT    = 12;
    localparam int HOLD_AFTER  = 150;   // results seen before the long receiver hold
    localparam int HOLD_CYCLES = 120;
    localparam int CALM_FIRST  = 300;   // positions sent while neither side idles
    localparam int CALM_LAST   = 450;

    localparam logic [HEAD_W-1:0] HEAD_EAST  = 16'h0000;
    localparam logic [HEAD_W-1:0] HEAD_NORTH = 16'h4000;
    localparam logic [HEAD_W-1:0] HEAD_SOUTH = 16'hC000;
    localparam logic [HEAD_W-1:0] HEAD_WEST  = 16'h8000;

    typedef struct {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        bit                     drain;  // marker: hold the sender until all results are back
    } position_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic [HEAD_W-1:0] head;
    } polar_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // x_position [15:0], y_position [31:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // distance_home [15:0], heading_home [31:16]

    position_t positions[$];
    polar_t    pending_polar[$];

    bit in_fire = 1'b0;
    int positions_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int drains_done = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    home_vector_polar #(
        .COORD_BITS (16),
        .ANGLE_BITS (16)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // floor of the euclidean norm, built up one root bit at a time
    function automatic logic [DIST_W-1:0] home_distance(logic signed [XY_W-1:0] px,
                                                        logic signed [XY_W-1:0] py);
        longint unsigned sq;
        longint unsigned root;
        longint unsigned trial;
        sq = longint'(px) * longint'(px) + longint'(py) * longint'(py);
        root = 0;
        for (int b = DIST_W; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root[DIST_W-1:0];
    endfunction

    // heading toward home, atan2(-y, -x), by vectoring rotation
    function automatic logic [HEAD_W-1:0] home_heading(logic signed [XY_W-1:0] px,
                                                       logic signed [XY_W-1:0] py);
        longint u;
        longint v;
        longint t;
        longint du;
        longint dv;
        longint acc;
        u = -longint'(px);
        v = -longint'(py);
        if (u == 0 && v == 0)
            return HEAD_EAST;
        if (v == 0)
            return (u > 0) ? HEAD_EAST : HEAD_WEST;
        if (u == 0)
            return (v > 0) ? HEAD_NORTH : HEAD_SOUTH;
        u = u <<< PRESCALE_SHIFT;
        v = v <<< PRESCALE_SHIFT;
        acc = 0;
        // fold the left half plane onto the right by a quarter turn
        if (u < 0) begin
            if (v >= 0) begin
                t = v; v = -u; u = t;
                acc = longint'(ACC_QUARTER);
            end else begin
                t = -v; v = u; u = t;
                acc = -longint'(ACC_QUARTER);
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            du = v >>> i;
            dv = u >>> i;
            if (v > 0) begin
                u = u + du; v = v - dv; acc = acc + longint'(ATAN_TAB[i]);
            end else begin
                u = u - du; v = v + dv; acc = acc - longint'(ATAN_TAB[i]);
            end
        end
        acc = (acc + (longint'(1) <<< (ACC_BITS - HEAD_W - 1))) >>> (ACC_BITS - HEAD_W);
        return acc[HEAD_W-1:0];
    endfunction

    function automatic logic signed [XY_W-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    task automatic add_position(input int px, input int py);
        position_t p;
        p.x = px[XY_W-1:0];
        p.y = py[XY_W-1:0];
        p.drain = 1'b0;
        positions.push_back(p);
    endtask

    task automatic add_drain();
        position_t p;
        p.x = '0;
        p.y = '0;
        p.drain = 1'b1;
        positions.push_back(p);
    endtask

    // sample both channels at the rising edge
    always @(posedge aclk) begin : sample
        polar_t want;
        polar_t got;
        logic signed [XY_W-1:0] sx;
        logic signed [XY_W-1:0] sy;
        if (!aresetn) begin
            in_fire = 1'b0;
        end else begin
            in_fire = s_axis_tvalid && s_axis_tready;
            if (in_fire) begin
                sx = s_axis_tdata[15:0];
                sy = s_axis_tdata[31:16];
                want.distance = home_distance(sx, sy);
                want.head = home_heading(sx, sy);
                pending_polar.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.distance = m_axis_tdata[15:0];
                got.head = m_axis_tdata[31:16];
                if (pending_polar.size() == 0) begin
                    $error("unexpected result transfer: distance_home %0d heading_home %0d",
                           got.distance, $signed(got.head));
                    mismatches++;
                end else begin
                    want = pending_polar.pop_front();
                    if (got.distance !== want.distance) begin
                        $error("distance_home: expected %0d, got %0d",
                               want.distance, got.distance);
                        mismatches++;
                    end
                    if (got.head !== want.head) begin
                        $error("heading_home: expected %0d, got %0d",
                               $signed(want.head), $signed(got.head));
                        mismatches++;
                    end
                    results_checked++;
                end
            end
        end
    end

    // sender: offers queued positions, stops at drain markers until all results are back
    always @(negedge aclk) begin : drive
        position_t p;
        logic next_valid;
        bit calm;
        if (aresetn) begin
            if (in_fire)
                positions_sent++;
            calm = positions_sent >= CALM_FIRST && positions_sent < CALM_LAST;
            if (!s_axis_tvalid || in_fire) begin
                next_valid = 1'b0;
                if (positions.size() != 0 && positions[0].drain && pending_polar.size() == 0) begin
                    void'(positions.pop_front());
                    drains_done++;
                end
                if (positions.size() != 0 && !positions[0].drain &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    p = positions.pop_front();
                    s_axis_tdata <= {p.y, p.x};
                    next_valid = 1'b1;
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    // receiver: random stalls, one long hold so the pipeline fills and backs up
    always @(negedge aclk) begin : accept
        bit calm;
        if (aresetn) begin
            calm = positions_sent >= CALM_FIRST && positions_sent < CALM_LAST;
            if (!hold_done && results_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    initial begin
        int kind;
        // at home, axes, corners, near the wrap at pi, a few ordinary points
        add_position(0, 0);
        add_position(32767, 0);
        add_position(-32768, 0);
        add_position(0, 32767);
        add_position(0, -32768);
        add_position(1, 0);
        add_position(-1, 0);
        add_position(0, 1);
        add_position(0, -1);
        add_position(-32768, -32768);
        add_position(32767, 32767);
        add_position(-32768, 32767);
        add_position(32767, -32768);
        add_position(32767, 1);
        add_position(32767, -1);
        add_position(-32768, 1);
        add_position(-32768, -1);
        add_position(1, 1);
        add_position(-1, -1);
        add_position(3, 4);
        add_position(-3, 4);
        add_position(5, -12);
        add_position(-20000, -15000);
        add_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 600)
                add_drain();
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: add_position($urandom_range(0, 65535) - 32768,
                                         $urandom_range(0, 65535) - 32768);
                4: add_position($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
                5: begin
                    if ($urandom_range(0, 1))
                        add_position($urandom_range(0, 65535) - 32768, 0);
                    else
                        add_position(0, $urandom_range(0, 65535) - 32768);
                end
                // on or just off the positive x axis, heading close to pi
                6: add_position($urandom_range(1, 32767), $urandom_range(0, 2) - 1);
                7: add_position(edge_coord(), edge_coord());
                8: add_position($urandom_range(0, 6) - 3, $urandom_range(0, 65535) - 32768);
                default: add_position($urandom_range(0, 600) - 300,
                                      $urandom_range(0, 600) - 300);
            endcase
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (positions.size() != 0 || s_axis_tvalid)
            @(posedge aclk);
        while (pending_polar.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (pending_polar.size() != 0) begin
            $error("%0d results never arrived", pending_polar.size());
            mismatches++;
        end
        $display("run covered %0d positions and %0d checked results, with %0d drains",
                 positions_sent, results_checked, drains_done);
        $display("and one %0d-cycle receiver hold that backed up the pipeline", HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("timeout with %0d results outstanding", pending_polar.size());
        $display("Verification failed");
        $finish;
    end

endmodule
